// File: hw/rtl/jda_pkg.sv
// shared types, constants and helpers for the joystick direction autorepeat block
`timescale 1ns / 1ps
`default_nettype none

package jda_pkg;

	localparam int SAMPLE_BITS   = 10;
	localparam int HOLD_BITS_DEF = 16;
	localparam int CENTER_BITS   = 10;
	localparam int DELAY_BITS    = 16;
	localparam int CFG_DATA_BITS = 16;
	localparam int CFG_IDX_BITS  = 2;
	localparam int DIR_BITS      = 4;
	localparam int REP_BITS      = 8;

	// offset magnitude and signed difference widths
	localparam int MAG_BITS  = (SAMPLE_BITS > CENTER_BITS) ? SAMPLE_BITS : CENTER_BITS;
	localparam int DIFF_BITS = MAG_BITS + 1;

	localparam logic [CENTER_BITS-1:0] CENTER_X_RST  = CENTER_BITS'(512);
	localparam logic [CENTER_BITS-1:0] CENTER_Y_RST  = CENTER_BITS'(512);
	localparam logic [CENTER_BITS-1:0] DEAD_ZONE_RST = CENTER_BITS'(20);
	localparam logic [DELAY_BITS-1:0]  DELAY_RST     = DELAY_BITS'(200);

	// magnitude bands and repeat limits
	localparam int BAND_SLOW   = 100;
	localparam int BAND_MID    = 200;
	localparam int BAND_FAST_X = 340;
	localparam int BAND_FAST_Y = 300;
	localparam int REP_DIV     = 10;
	localparam logic [REP_BITS-1:0] LIMIT_SLOW    = REP_BITS'(1000 / REP_DIV);
	localparam logic [REP_BITS-1:0] LIMIT_MID     = REP_BITS'(500 / REP_DIV);
	localparam logic [REP_BITS-1:0] LIMIT_FAST    = REP_BITS'(250 / REP_DIV);
	localparam logic [REP_BITS-1:0] LIMIT_FASTEST = REP_BITS'(100 / REP_DIV);
	localparam logic [REP_BITS-1:0] REP_STEP      = REP_BITS'(2);

	// positions in the direction code
	localparam int DIR_UP    = 0;
	localparam int DIR_DOWN  = 1;
	localparam int DIR_LEFT  = 2;
	localparam int DIR_RIGHT = 3;

	// per-axis direction: bit 0 positive, bit 1 negative
	localparam int AXIS_POS = 0;
	localparam int AXIS_NEG = 1;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_CENTER_X  = 2'd0,
		REG_CENTER_Y  = 2'd1,
		REG_DEAD_ZONE = 2'd2,
		REG_DELAY     = 2'd3
	} reg_index_e;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] raw_x;
		logic [SAMPLE_BITS-1:0] raw_y;
		logic                   button_n;
	} in_item_t;

	typedef struct packed {
		logic [DIR_BITS-1:0] dir_bits;
		logic                button_pressed;
		logic                dir_changed;
		logic                button_changed;
	} out_item_t;

	typedef struct packed {
		logic [CENTER_BITS-1:0] center_x;
		logic [CENTER_BITS-1:0] center_y;
		logic [CENTER_BITS-1:0] dead_zone;
		logic [DELAY_BITS-1:0]  initial_delay;
	} cfg_t;

	typedef struct packed {
		logic                rearm;
		logic [REP_BITS-1:0] count;
	} axis_state_t;

	function automatic logic [MAG_BITS-1:0] mag_of(input logic signed [DIFF_BITS-1:0] d);
		logic [DIFF_BITS-1:0] neg;
		neg = -d;
		return d[DIFF_BITS-1] ? neg[MAG_BITS-1:0] : d[MAG_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/jda_cfg_regs.sv
// configuration registers: centers, dead zone and initial delay
`timescale 1ns / 1ps
`default_nettype none

module jda_cfg_regs (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [jda_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  wire logic [jda_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	output jda_pkg::cfg_t                             cfg
);

	jda_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x      <= jda_pkg::CENTER_X_RST;
			cfg_q.center_y      <= jda_pkg::CENTER_Y_RST;
			cfg_q.dead_zone     <= jda_pkg::DEAD_ZONE_RST;
			cfg_q.initial_delay <= jda_pkg::DELAY_RST;
		end else if (cfg_we) begin
			case (jda_pkg::reg_index_e'(cfg_index))
				jda_pkg::REG_CENTER_X: begin
					cfg_q.center_x <= cfg_data[jda_pkg::CENTER_BITS-1:0];
				end
				jda_pkg::REG_CENTER_Y: begin
					cfg_q.center_y <= cfg_data[jda_pkg::CENTER_BITS-1:0];
				end
				jda_pkg::REG_DEAD_ZONE: begin
					cfg_q.dead_zone <= cfg_data[jda_pkg::CENTER_BITS-1:0];
				end
				jda_pkg::REG_DELAY: begin
					cfg_q.initial_delay <= cfg_data[jda_pkg::DELAY_BITS-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: hw/rtl/jda_axis.sv
// one axis: dead zone, hold delay and magnitude-banded repeat
`timescale 1ns / 1ps
`default_nettype none

module jda_axis #(
	parameter int HOLD_BITS = jda_pkg::HOLD_BITS_DEF,
	parameter int BAND_FAST = jda_pkg::BAND_FAST_X
) (
	input  wire logic [jda_pkg::MAG_BITS-1:0] mag,
	input  wire logic [jda_pkg::MAG_BITS-1:0] other_mag,
	input  wire logic [1:0]                   sign_code,
	input  wire jda_pkg::cfg_t                cfg,
	input  wire jda_pkg::axis_state_t         st_cur,
	input  wire logic [HOLD_BITS-1:0]         hold_cur,
	output jda_pkg::axis_state_t              st_nxt,
	output logic      [HOLD_BITS-1:0]         hold_nxt,
	output logic      [1:0]                   dir
);

	localparam int CMP_BITS = (HOLD_BITS > jda_pkg::DELAY_BITS) ?
		HOLD_BITS : jda_pkg::DELAY_BITS;

	logic [HOLD_BITS-1:0]         hold_inc;
	logic                         centered;
	logic                         other_centered;
	logic                         before_delay;
	logic [jda_pkg::REP_BITS-1:0] count_step;
	logic [jda_pkg::REP_BITS-1:0] limit;

	assign hold_inc       = (hold_cur == '1) ? hold_cur : hold_cur + 1'b1;
	assign centered       = mag < jda_pkg::MAG_BITS'(cfg.dead_zone);
	assign other_centered = other_mag < jda_pkg::MAG_BITS'(cfg.dead_zone);
	assign before_delay   = CMP_BITS'(hold_cur) < CMP_BITS'(cfg.initial_delay);
	assign count_step     = st_cur.count + jda_pkg::REP_STEP;

	always_comb begin
		if (mag < jda_pkg::MAG_BITS'(jda_pkg::BAND_SLOW)) begin
			limit = jda_pkg::LIMIT_SLOW;
		end else if (mag < jda_pkg::MAG_BITS'(jda_pkg::BAND_MID)) begin
			limit = jda_pkg::LIMIT_MID;
		end else if (mag < jda_pkg::MAG_BITS'(BAND_FAST)) begin
			limit = jda_pkg::LIMIT_FAST;
		end else begin
			limit = jda_pkg::LIMIT_FASTEST;
		end
	end

	always_comb begin
		st_nxt   = st_cur;
		hold_nxt = hold_cur;
		dir      = 2'b00;
		if (centered) begin
			st_nxt.rearm = 1'b1;
			hold_nxt     = other_centered ? '0 : hold_inc;
		end else if (before_delay) begin
			hold_nxt = hold_inc;
			dir      = sign_code;
		end else if (st_cur.rearm) begin
			st_nxt.rearm = 1'b0;
			st_nxt.count = '0;
			dir          = sign_code;
		end else begin
			st_nxt.count = count_step;
			if (count_step >= limit) begin
				st_nxt.rearm = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/jda_core.sv
// decode state and per-request direction logic for both axes
`timescale 1ns / 1ps
`default_nettype none

module jda_core #(
	parameter int HOLD_BITS = jda_pkg::HOLD_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire jda_pkg::in_item_t  item,
	input  wire jda_pkg::cfg_t      cfg,
	output jda_pkg::out_item_t      result
);

	logic signed [jda_pkg::DIFF_BITS-1:0] dx;
	logic signed [jda_pkg::DIFF_BITS-1:0] dy;
	logic [jda_pkg::MAG_BITS-1:0]         mx;
	logic [jda_pkg::MAG_BITS-1:0]         my;
	logic [1:0]                           sx;
	logic [1:0]                           sy;
	logic [1:0]                           xs;
	logic [1:0]                           ys;
	logic [jda_pkg::DIR_BITS-1:0]         dir;
	logic                                 pressed;

	jda_pkg::axis_state_t st_x_q, st_y_q, st_x_nxt, st_y_nxt;
	logic [HOLD_BITS-1:0] hold_q, hold_mid, hold_nxt;
	logic [jda_pkg::DIR_BITS-1:0] last_dir_q;
	logic                         last_button_q;

	// positive x is right, positive y is up
	assign dx = $signed(jda_pkg::DIFF_BITS'(cfg.center_x) - jda_pkg::DIFF_BITS'(item.raw_x));
	assign dy = $signed(jda_pkg::DIFF_BITS'(item.raw_y) - jda_pkg::DIFF_BITS'(cfg.center_y));
	assign mx = jda_pkg::mag_of(dx);
	assign my = jda_pkg::mag_of(dy);

	assign sx[jda_pkg::AXIS_POS] = (dx != '0) && !dx[jda_pkg::DIFF_BITS-1];
	assign sx[jda_pkg::AXIS_NEG] = dx[jda_pkg::DIFF_BITS-1];
	assign sy[jda_pkg::AXIS_POS] = (dy != '0) && !dy[jda_pkg::DIFF_BITS-1];
	assign sy[jda_pkg::AXIS_NEG] = dy[jda_pkg::DIFF_BITS-1];

	jda_axis #(
		.HOLD_BITS (HOLD_BITS),
		.BAND_FAST (jda_pkg::BAND_FAST_X)
	) u_axis_x (
		.mag       (mx),
		.other_mag (my),
		.sign_code (sx),
		.cfg       (cfg),
		.st_cur    (st_x_q),
		.hold_cur  (hold_q),
		.st_nxt    (st_x_nxt),
		.hold_nxt  (hold_mid),
		.dir       (xs)
	);

	// y sees the hold count left by x
	jda_axis #(
		.HOLD_BITS (HOLD_BITS),
		.BAND_FAST (jda_pkg::BAND_FAST_Y)
	) u_axis_y (
		.mag       (my),
		.other_mag (mx),
		.sign_code (sy),
		.cfg       (cfg),
		.st_cur    (st_y_q),
		.hold_cur  (hold_mid),
		.st_nxt    (st_y_nxt),
		.hold_nxt  (hold_nxt),
		.dir       (ys)
	);

	// minor axis suppressed, equal magnitudes keep both
	always_comb begin
		dir                     = '0;
		dir[jda_pkg::DIR_UP]    = ys[jda_pkg::AXIS_POS] && !(mx > my);
		dir[jda_pkg::DIR_DOWN]  = ys[jda_pkg::AXIS_NEG] && !(mx > my);
		dir[jda_pkg::DIR_LEFT]  = xs[jda_pkg::AXIS_NEG] && !(mx < my);
		dir[jda_pkg::DIR_RIGHT] = xs[jda_pkg::AXIS_POS] && !(mx < my);
	end

	assign pressed = !item.button_n;

	always_comb begin
		result.dir_bits       = dir;
		result.button_pressed = pressed;
		result.dir_changed    = dir != last_dir_q;
		result.button_changed = pressed != last_button_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_x_q        <= '0;
			st_y_q        <= '0;
			hold_q        <= '0;
			last_dir_q    <= '0;
			last_button_q <= 1'b0;
		end else if (step) begin
			st_x_q        <= st_x_nxt;
			st_y_q        <= st_y_nxt;
			hold_q        <= hold_nxt;
			last_dir_q    <= dir;
			last_button_q <= pressed;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/joystick_direction_autorepeat.sv
// top level: request input register, decode core and result register
//
// channel   signals                          dir  notes
// in        in_valid, in_ready, in_data      in   raw_x, raw_y, button_n
// out       out_valid, out_ready, out_data   out  one result per request
// cfg       cfg_we, cfg_index, cfg_data      in   write only, no wait
//
// one request per cycle while out_ready holds; registered at input and at result
// the decode is one combinational pass from the input register to the result register
// a stalled result holds in the result register while the input register still fills
// arst_n clears the valid flags and core state and loads the register reset values
`timescale 1ns / 1ps
`default_nettype none

module joystick_direction_autorepeat #(
	parameter int HOLD_BITS = jda_pkg::HOLD_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire jda_pkg::in_item_t                 in_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output jda_pkg::out_item_t                     out_data,
	input  wire logic                              cfg_we,
	input  wire logic [jda_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [jda_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	jda_pkg::cfg_t      cfg;
	jda_pkg::in_item_t  item_s1;
	logic               valid_s1;
	jda_pkg::out_item_t result;
	jda_pkg::out_item_t out_q;
	logic               out_valid_q;
	logic               advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	jda_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	jda_core #(
		.HOLD_BITS (HOLD_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire
